// ===== hdl/rps_pkg.sv =====
// Shared constants, types and codes for the rotating priority selector.
package rps_pkg;

   localparam int NUM_ENTRIES   = 64;
   localparam int NUM_CPUS      = 8;
   localparam int PRIORITY_BITS = 8;

   localparam int ENTRY_IDX_W = $clog2(NUM_ENTRIES);
   localparam int CPU_IDX_W   = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;

   // fixed port field widths
   localparam int INDEX_FIELD_W = 6;
   localparam int PRIO_FIELD_W  = 8;
   localparam int CPU_FIELD_W   = 3;

   localparam logic [ENTRY_IDX_W-1:0] LAST_ENTRY = ENTRY_IDX_W'(NUM_ENTRIES - 1);

   localparam logic REQ_UPDATE = 1'b0;
   localparam logic REQ_SELECT = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                     rdy;
      logic [PRIORITY_BITS-1:0] prio;
   } entry_type;

   typedef struct packed {
      logic                   init;
      logic                   step;
      logic [ENTRY_IDX_W-1:0] start;
   } pick_ctl_type;

   typedef struct packed {
      logic                     have;
      logic [ENTRY_IDX_W-1:0]   idx;
      logic [PRIORITY_BITS-1:0] prio;
      logic                     last;
   } pick_stat_type;

endpackage

// ===== hdl/rps_cell.sv =====
// One ring cell: holds a table entry, takes a write or its neighbor's entry.
module rps_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               shift,
   input  logic               wr_en,
   input  rps_pkg::entry_type wr_data,
   input  rps_pkg::entry_type from_next,
   output rps_pkg::entry_type q
);

   rps_pkg::entry_type entry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else if (wr_en) begin
         entry_ff <= wr_data;
      end else if (shift) begin
         entry_ff <= from_next;
      end
   end

   assign q = entry_ff;

endmodule

// ===== hdl/rps_pick.sv =====
// Running best-entry tracker fed by the ring head, one entry per cycle while stepped.
module rps_pick (
   input  logic                  clock,
   input  logic                  reset,
   input  rps_pkg::pick_ctl_type ctl,
   input  rps_pkg::entry_type    head,
   output rps_pkg::pick_stat_type stat
);

   logic                              have_ff;
   logic [rps_pkg::ENTRY_IDX_W-1:0]   idx_ff;
   logic [rps_pkg::PRIORITY_BITS-1:0] prio_ff;
   logic [rps_pkg::ENTRY_IDX_W-1:0]   dist_ff;
   logic [rps_pkg::ENTRY_IDX_W-1:0]   pos_ff;
   logic [rps_pkg::ENTRY_IDX_W-1:0]   cur_dist_ff;
   logic [rps_pkg::ENTRY_IDX_W-1:0]   dist_init_in;
   logic                              take;

   // distance of entry 0 from the start cursor, modulo the table size
   assign dist_init_in = (ctl.start == '0) ? '0 :
      rps_pkg::ENTRY_IDX_W'((rps_pkg::ENTRY_IDX_W+1)'(rps_pkg::NUM_ENTRIES)
                            - {1'b0, ctl.start});

   // ties go to the entry nearer the cursor in wrap order
   assign take = head.rdy &&
                 (!have_ff || (head.prio > prio_ff) ||
                  ((head.prio == prio_ff) && (cur_dist_ff < dist_ff)));

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff     <= 1'b0;
         pos_ff      <= '0;
         cur_dist_ff <= '0;
      end else if (ctl.init) begin
         have_ff     <= 1'b0;
         pos_ff      <= '0;
         cur_dist_ff <= dist_init_in;
      end else if (ctl.step) begin
         if (take) begin
            have_ff <= 1'b1;
            idx_ff  <= pos_ff;
            prio_ff <= head.prio;
            dist_ff <= cur_dist_ff;
         end
         pos_ff      <= pos_ff + 1'b1;
         cur_dist_ff <= (cur_dist_ff == rps_pkg::LAST_ENTRY) ? '0 : cur_dist_ff + 1'b1;
      end
   end

   assign stat.have = have_ff;
   assign stat.idx  = idx_ff;
   assign stat.prio = prio_ff;
   assign stat.last = (pos_ff == rps_pkg::LAST_ENTRY);

endmodule

// ===== hdl/rotating_priority_selector_unit.sv =====
// Rotating priority selector: ring of entry cells, best tracker, cursors and control.
// Update beat: result register loaded at the accepting edge.
// Select beat: the cell ring rotates a full lap past the tracker in ST_SCAN, then
// ST_DONE loads the result once the output is free; one beat in flight at a time.
// Throughput: updates every cycle while rsp_ready holds; a select holds req_ready low.
// Synchronous reset clears all entries, all cursors and the result valid.
module rotating_priority_selector_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_type,
   input  logic [rps_pkg::INDEX_FIELD_W-1:0]   req_entry_index,
   input  logic                                req_runnable,
   input  logic [rps_pkg::PRIO_FIELD_W-1:0]    req_priority_req,
   input  logic [rps_pkg::CPU_FIELD_W-1:0]     req_cpu,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_found,
   output logic [rps_pkg::INDEX_FIELD_W-1:0]   rsp_chosen_index,
   output logic [rps_pkg::PRIO_FIELD_W-1:0]    rsp_chosen_priority
);

   localparam int IW = rps_pkg::ENTRY_IDX_W + rps_pkg::INDEX_FIELD_W;
   localparam int PW = rps_pkg::PRIORITY_BITS + rps_pkg::PRIO_FIELD_W;
   localparam int CW = rps_pkg::CPU_IDX_W + rps_pkg::CPU_FIELD_W;

   rps_pkg::state_type                 state_ff, state_in;
   logic [rps_pkg::CPU_IDX_W-1:0]      cpu_ff, cpu_in;
   logic [rps_pkg::ENTRY_IDX_W-1:0]    cursor_ff [rps_pkg::NUM_CPUS];
   logic                               rsp_valid_ff;
   logic                               rsp_found_ff, rsp_found_in;
   logic [rps_pkg::INDEX_FIELD_W-1:0]  rsp_index_ff, rsp_index_in;
   logic [rps_pkg::PRIO_FIELD_W-1:0]   rsp_prio_ff, rsp_prio_in;

   logic                               req_fire;
   logic                               rsp_load;
   logic                               out_free;
   logic                               upd_fire;
   logic                               shift;
   logic                               cursor_we;
   logic [rps_pkg::ENTRY_IDX_W-1:0]    cursor_next;

   logic [IW-1:0]                      req_idx_ext;
   logic                               idx_ok;
   logic [rps_pkg::ENTRY_IDX_W-1:0]    wr_idx;
   logic [PW-1:0]                      req_prio_ext;
   logic [CW-1:0]                      req_cpu_ext;
   logic                               cpu_ok;
   logic [rps_pkg::CPU_IDX_W-1:0]      req_cpu_idx;
   logic [IW-1:0]                      best_idx_ext;
   logic [PW-1:0]                      best_prio_ext;

   rps_pkg::entry_type                 wr_data;
   rps_pkg::entry_type                 cell_q [rps_pkg::NUM_ENTRIES];
   rps_pkg::pick_ctl_type              pick_ctl;
   rps_pkg::pick_stat_type             pick_stat;

   assign req_idx_ext  = IW'(req_entry_index);
   assign idx_ok       = req_idx_ext < IW'(rps_pkg::NUM_ENTRIES);
   assign wr_idx       = req_idx_ext[rps_pkg::ENTRY_IDX_W-1:0];
   assign req_prio_ext = PW'(req_priority_req);
   assign req_cpu_ext  = CW'(req_cpu);
   assign cpu_ok       = req_cpu_ext < CW'(rps_pkg::NUM_CPUS);
   assign req_cpu_idx  = req_cpu_ext[rps_pkg::CPU_IDX_W-1:0];
   assign best_idx_ext  = IW'(pick_stat.idx);
   assign best_prio_ext = PW'(pick_stat.prio);

   assign wr_data.rdy  = req_runnable;
   assign wr_data.prio = req_prio_ext[rps_pkg::PRIORITY_BITS-1:0];

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == rps_pkg::ST_IDLE) && out_free;
   assign req_fire  = req_valid && req_ready;

   assign cursor_next = (pick_stat.idx == rps_pkg::LAST_ENTRY) ? '0 : pick_stat.idx + 1'b1;

   // ring: cell i loads from cell i+1, head is cell 0; N shifts restore the order
   for (genvar i = 0; i < rps_pkg::NUM_ENTRIES; i++) begin : g_cell
      localparam int NEXT = (i + 1) % rps_pkg::NUM_ENTRIES;
      rps_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift     (shift),
         .wr_en     (upd_fire && idx_ok && (wr_idx == rps_pkg::ENTRY_IDX_W'(i))),
         .wr_data   (wr_data),
         .from_next (cell_q[NEXT]),
         .q         (cell_q[i])
      );
   end

   rps_pick u_pick (
      .clock (clock),
      .reset (reset),
      .ctl   (pick_ctl),
      .head  (cell_q[0]),
      .stat  (pick_stat)
   );

   always_comb begin
      state_in       = state_ff;
      cpu_in         = cpu_ff;
      rsp_load       = 1'b0;
      rsp_found_in   = 1'b0;
      rsp_index_in   = '0;
      rsp_prio_in    = '0;
      upd_fire       = 1'b0;
      shift          = 1'b0;
      cursor_we      = 1'b0;
      pick_ctl.init  = 1'b0;
      pick_ctl.step  = 1'b0;
      pick_ctl.start = cursor_ff[req_cpu_idx];
      case (state_ff)
         rps_pkg::ST_IDLE: begin
            if (req_fire) begin
               if ((req_type == rps_pkg::REQ_SELECT) && cpu_ok) begin
                  pick_ctl.init = 1'b1;
                  cpu_in        = req_cpu_idx;
                  state_in      = rps_pkg::ST_SCAN;
               end else begin
                  // updates and selects for absent cpus answer all-zero at once
                  rsp_load = 1'b1;
                  upd_fire = (req_type == rps_pkg::REQ_UPDATE);
               end
            end
         end
         rps_pkg::ST_SCAN: begin
            shift         = 1'b1;
            pick_ctl.step = 1'b1;
            if (pick_stat.last) begin
               state_in = rps_pkg::ST_DONE;
            end
         end
         rps_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_load     = 1'b1;
               rsp_found_in = pick_stat.have;
               if (pick_stat.have) begin
                  rsp_index_in = best_idx_ext[rps_pkg::INDEX_FIELD_W-1:0];
                  rsp_prio_in  = best_prio_ext[rps_pkg::PRIO_FIELD_W-1:0];
               end
               cursor_we = pick_stat.have;
               state_in  = rps_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rps_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rps_pkg::ST_IDLE;
         cpu_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < rps_pkg::NUM_CPUS; c++) begin
            cursor_ff[c] <= '0;
         end
      end else begin
         state_ff <= state_in;
         cpu_ff   <= cpu_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cursor_we) begin
            cursor_ff[cpu_ff] <= cursor_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_found_ff <= rsp_found_in;
         rsp_index_ff <= rsp_index_in;
         rsp_prio_ff  <= rsp_prio_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_found           = rsp_found_ff;
   assign rsp_chosen_index    = rsp_index_ff;
   assign rsp_chosen_priority = rsp_prio_ff;

endmodule

// ===== bench/rps_result_checker.sv =====
// Scoreboard for the rotating priority selector: predicts every result beat and compares it.
module rps_result_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic                              req_type,
   input  logic [rps_pkg::INDEX_FIELD_W-1:0] req_entry_index,
   input  logic                              req_runnable,
   input  logic [rps_pkg::PRIO_FIELD_W-1:0]  req_priority_req,
   input  logic [rps_pkg::CPU_FIELD_W-1:0]   req_cpu,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic                              rsp_found,
   input  logic [rps_pkg::INDEX_FIELD_W-1:0] rsp_chosen_index,
   input  logic [rps_pkg::PRIO_FIELD_W-1:0]  rsp_chosen_priority,
   output int                                fail_count,
   output int                                pending,
   output int                                hit_count
);

   typedef struct packed {
      logic                              found;
      logic [rps_pkg::INDEX_FIELD_W-1:0] idx;
      logic [rps_pkg::PRIO_FIELD_W-1:0]  prio;
   } pick_type;

   logic                              run_flag   [rps_pkg::NUM_ENTRIES];
   logic [rps_pkg::PRIORITY_BITS-1:0] prio_mem   [rps_pkg::NUM_ENTRIES];
   logic [rps_pkg::ENTRY_IDX_W-1:0]   cursor_mem [rps_pkg::NUM_CPUS];
   pick_type                          picks_due  [$];
   int                                mismatches;
   int                                hits;
   pick_type                          got;
   pick_type                          want;

   // one full lap from the cpu's cursor; strict compare keeps the first of equal priorities
   function automatic pick_type pick_winner(input logic [rps_pkg::CPU_FIELD_W-1:0] c);
      pick_type                          best;
      logic [rps_pkg::PRIORITY_BITS-1:0] best_prio;
      int                                pos;
      int                                best_pos;
      best      = '0;
      best_prio = '0;
      best_pos  = 0;
      if (int'(c) < rps_pkg::NUM_CPUS) begin
         pos = int'(cursor_mem[c]);
         for (int n = 0; n < rps_pkg::NUM_ENTRIES; n++) begin
            if (run_flag[pos] && (!best.found || prio_mem[pos] > best_prio)) begin
               best.found = 1'b1;
               best_prio  = prio_mem[pos];
               best_pos   = pos;
            end
            pos = (pos + 1) % rps_pkg::NUM_ENTRIES;
         end
         if (best.found) begin
            cursor_mem[c] = rps_pkg::ENTRY_IDX_W'((best_pos + 1) % rps_pkg::NUM_ENTRIES);
            best.idx      = rps_pkg::INDEX_FIELD_W'(best_pos);
            best.prio     = rps_pkg::PRIO_FIELD_W'(best_prio);
         end
      end
      return best;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < rps_pkg::NUM_ENTRIES; i++) begin
            run_flag[i] = 1'b0;
            prio_mem[i] = '0;
         end
         for (int i = 0; i < rps_pkg::NUM_CPUS; i++) cursor_mem[i] = '0;
         picks_due.delete();
         mismatches = 0;
         hits       = 0;
      end else begin
         // result side first: a beat leaving now belongs to an earlier request
         if (rsp_valid && rsp_ready) begin
            got.found = rsp_found;
            got.idx   = rsp_chosen_index;
            got.prio  = rsp_chosen_priority;
            if (picks_due.size() == 0) begin
               if (mismatches < 10)
                  $display("checker: unexpected beat: found=%0b idx=%0d prio=%0d",
                           got.found, got.idx, got.prio);
               mismatches++;
            end else begin
               want = picks_due.pop_front();
               if (got.found !== want.found || got.idx !== want.idx || got.prio !== want.prio)
               begin
                  if (mismatches < 10)
                     $display("checker: expected %0b/%0d/%0d got %0b/%0d/%0d",
                              want.found, want.idx, want.prio, got.found, got.idx, got.prio);
                  mismatches++;
               end
               if (want.found) hits++;
            end
         end
         if (req_valid && req_ready) begin
            if (req_type == rps_pkg::REQ_UPDATE) begin
               if (int'(req_entry_index) < rps_pkg::NUM_ENTRIES) begin
                  run_flag[req_entry_index] = req_runnable;
                  prio_mem[req_entry_index] = rps_pkg::PRIORITY_BITS'(req_priority_req);
               end
               picks_due.push_back('0);
            end else begin
               picks_due.push_back(pick_winner(req_cpu));
            end
         end
      end
      fail_count <= mismatches;
      hit_count  <= hits;
      pending    <= picks_due.size();
   end

endmodule

// ===== bench/tb_rotating_priority_selector_unit.sv =====
// Testbench top for the rotating priority selector: stimulus, handshake idling and verdict.
module tb_rotating_priority_selector_unit;

   localparam int CYCLE_LIMIT = 800_000;

   logic                              clock               = 1'b0;
   logic                              reset               = 1'b1;
   logic                              req_valid           = 1'b0;
   logic                              req_ready;
   logic                              req_type            = rps_pkg::REQ_UPDATE;
   logic [rps_pkg::INDEX_FIELD_W-1:0] req_entry_index     = '0;
   logic                              req_runnable        = 1'b0;
   logic [rps_pkg::PRIO_FIELD_W-1:0]  req_priority_req    = '0;
   logic [rps_pkg::CPU_FIELD_W-1:0]   req_cpu             = '0;
   logic                              rsp_valid;
   logic                              rsp_ready           = 1'b0;
   logic                              rsp_found;
   logic [rps_pkg::INDEX_FIELD_W-1:0] rsp_chosen_index;
   logic [rps_pkg::PRIO_FIELD_W-1:0]  rsp_chosen_priority;

   int fail_count;
   int pending;
   int hit_count;
   int cycles       = 0;
   int rsp_hold     = 0;
   int updates_sent = 0;
   int selects_sent = 0;
   bit calm         = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   rotating_priority_selector_unit uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_type            (req_type),
      .req_entry_index     (req_entry_index),
      .req_runnable        (req_runnable),
      .req_priority_req    (req_priority_req),
      .req_cpu             (req_cpu),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_found           (rsp_found),
      .rsp_chosen_index    (rsp_chosen_index),
      .rsp_chosen_priority (rsp_chosen_priority)
   );

   rps_result_checker pick_check (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_type            (req_type),
      .req_entry_index     (req_entry_index),
      .req_runnable        (req_runnable),
      .req_priority_req    (req_priority_req),
      .req_cpu             (req_cpu),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_found           (rsp_found),
      .rsp_chosen_index    (rsp_chosen_index),
      .rsp_chosen_priority (rsp_chosen_priority),
      .fail_count          (fail_count),
      .pending             (pending),
      .hit_count           (hit_count)
   );

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (calm) return 0;
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 80);
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb_rotating_priority_selector_unit failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_hold  <= rsp_hold - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (!calm && $urandom_range(0, 3) == 0) rsp_hold <= gap_len();
      end
   end

   // valid stays up across back-to-back beats; it drops only when a gap is taken or in drain
   task automatic send_beat(input logic t, input logic [rps_pkg::INDEX_FIELD_W-1:0] idx,
                            input logic run, input logic [rps_pkg::PRIO_FIELD_W-1:0] pr,
                            input logic [rps_pkg::CPU_FIELD_W-1:0] c);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_type         <= t;
      req_entry_index  <= idx;
      req_runnable     <= run;
      req_priority_req <= pr;
      req_cpu          <= c;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (t == rps_pkg::REQ_UPDATE) updates_sent++;
      else selects_sent++;
   endtask

   // wait on the clock before polling so the checker's registered count covers the last accepted beat
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic rand_beat(input bit ties, input int run_pct);
      logic [rps_pkg::PRIO_FIELD_W-1:0] pr;
      logic                             t;
      int                               k;
      t = ($urandom_range(0, 99) < 45) ? rps_pkg::REQ_SELECT : rps_pkg::REQ_UPDATE;
      k = $urandom_range(0, 3);
      if (!ties) pr = rps_pkg::PRIO_FIELD_W'($urandom);
      else if (k == 0) pr = '0;
      else if (k == 1) pr = '1;
      else if (k == 2) pr = rps_pkg::PRIO_FIELD_W'($urandom_range(0, 3));
      else pr = rps_pkg::PRIO_FIELD_W'($urandom_range(252, 255));
      // unused fields of each beat type carry random noise
      send_beat(t, rps_pkg::INDEX_FIELD_W'($urandom), $urandom_range(0, 99) < run_pct, pr,
                rps_pkg::CPU_FIELD_W'($urandom));
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // empty table, both cpu extremes
      send_beat(rps_pkg::REQ_SELECT, 6'd0, 1'b0, 8'd0, 3'd0);
      send_beat(rps_pkg::REQ_SELECT, 6'd63, 1'b1, 8'd255, 3'd7);
      // a ready entry at priority zero still wins
      send_beat(rps_pkg::REQ_UPDATE, 6'd0, 1'b1, 8'd0, 3'd0);
      send_beat(rps_pkg::REQ_SELECT, 6'd0, 1'b0, 8'd0, 3'd0);
      // tie at top priority: first met from the cursor wins, cursor wraps past 63
      send_beat(rps_pkg::REQ_UPDATE, 6'd63, 1'b1, 8'd255, 3'd7);
      send_beat(rps_pkg::REQ_UPDATE, 6'd10, 1'b1, 8'd255, 3'd2);
      send_beat(rps_pkg::REQ_SELECT, 6'd0, 1'b0, 8'd0, 3'd7);
      send_beat(rps_pkg::REQ_SELECT, 6'd0, 1'b0, 8'd0, 3'd0);
      send_beat(rps_pkg::REQ_SELECT, 6'd0, 1'b0, 8'd0, 3'd7);
      send_beat(rps_pkg::REQ_SELECT, 6'd0, 1'b0, 8'd0, 3'd7);
      // clearing the ready flag removes the entry
      send_beat(rps_pkg::REQ_UPDATE, 6'd10, 1'b0, 8'd255, 3'd5);
      send_beat(rps_pkg::REQ_SELECT, 6'd21, 1'b1, 8'd170, 3'd3);
      send_beat(rps_pkg::REQ_UPDATE, 6'd42, 1'b1, 8'd85, 3'd1);
      send_beat(rps_pkg::REQ_UPDATE, 6'd21, 1'b1, 8'd170, 3'd6);
      send_beat(rps_pkg::REQ_SELECT, 6'd0, 1'b0, 8'd0, 3'd5);
      // empty again: cursor must stay put
      send_beat(rps_pkg::REQ_UPDATE, 6'd0, 1'b0, 8'd0, 3'd0);
      send_beat(rps_pkg::REQ_UPDATE, 6'd63, 1'b0, 8'd0, 3'd0);
      send_beat(rps_pkg::REQ_UPDATE, 6'd42, 1'b0, 8'd0, 3'd0);
      send_beat(rps_pkg::REQ_UPDATE, 6'd21, 1'b0, 8'd0, 3'd0);
      send_beat(rps_pkg::REQ_SELECT, 6'd0, 1'b0, 8'd0, 3'd1);
      send_beat(rps_pkg::REQ_SELECT, 6'd0, 1'b0, 8'd0, 3'd6);
      send_beat(rps_pkg::REQ_UPDATE, 6'd5, 1'b1, 8'd1, 3'd0);
      send_beat(rps_pkg::REQ_SELECT, 6'd0, 1'b0, 8'd0, 3'd6);
      drain();

      for (int p = 0; p < 4; p++) begin
         calm = (p == 2);
         for (int i = 0; i < 160; i++) rand_beat(p % 2 == 1, (p == 3) ? 20 : 70);
         drain();
      end
      calm = 1'b0;

      repeat (80) @(posedge clock);
      $display("covered %0d update beats and %0d select beats, %0d selects found an entry",
               updates_sent, selects_sent, hit_count);
      $display("phases: full-range and tie-heavy priorities, sparse ready set, one idle-free run");
      if (fail_count == 0) begin
         $display("tb_rotating_priority_selector_unit passed");
      end else begin
         $display("tb_rotating_priority_selector_unit failed");
      end
      $finish;
   end

endmodule
